[src/zpc_pkg.sv]
package zpc_pkg;

  // default values of the top level parameters
  localparam int KERNEL_SIZE_DEF = 5;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int PIXEL_BITS_DEF  = 8;
  localparam int COEF_BITS_DEF   = 12;

  // largest kernel the coefficient registers can hold
  localparam int MAX_KERNEL = 5;

  // result fields
  localparam int SUM_BITS = 25;
  localparam int OUT_BITS = 8;
  localparam logic [OUT_BITS-1:0] OUT_MAX = 8'hFF;

  // configuration port
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 60;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 16;
  localparam int SHIFT_REG_BITS  = 4;

  // scan row runs a little past the frame height while the lag drains
  localparam int ROW_BITS = HEIGHT_REG_BITS + 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW_0   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW_1   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW_2   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW_3   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW_4   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAC_SHIFT   = 3'd7;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd1024;
  localparam logic [SHIFT_REG_BITS-1:0]  SHIFT_RESET  = 4'd10;

endpackage

[src/zpc_ifs.sv]
// pixel stream
interface zpc_pix_if #(
  parameter int PIXEL_BITS = zpc_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;
  logic                  filler;

  modport source (output valid, pixel_in, filler, input ready);
  modport sink (input valid, pixel_in, filler, output ready);
endinterface

// filtered result stream
interface zpc_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [zpc_pkg::SUM_BITS-1:0] raw_sum;
  logic [zpc_pkg::OUT_BITS-1:0]        out_pixel;
  logic                                saturated;
  logic                                end_of_row;
  logic                                end_of_frame;

  modport source (output valid, raw_sum, out_pixel, saturated, end_of_row, end_of_frame,
                  input ready);
  modport sink (input valid, raw_sum, out_pixel, saturated, end_of_row, end_of_frame,
                output ready);
endinterface

// register writes
interface zpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [zpc_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [zpc_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/zero_padded_2d_convolution.sv]
// zero padded 2d convolution, centered KERNEL_SIZE x KERNEL_SIZE window
//
// pixels: raster order pixel stream, one transfer per pixel. after the last
//   pixel of a frame the sender pushes filler transfers to drain the window
//   lag (AFTER rows plus AFTER pixels, AFTER = KERNEL_SIZE-1-KERNEL_SIZE/2)
// results: one transfer per image position in raster order, with the raw
//   signed sum, the rounded and clipped magnitude, and row / frame end marks
// cfg: register writes (kernel rows, image size, rounding shift); always
//   ready outside reset, meant to be used while the block is drained
//
// throughput is one pixel per clock unless the receiver stalls: every pixel does
// one read and one write in each line store, and every stage after that is fully pipelined
// a result passes the stage 1 to stage 5 registers and the output register after
//   the transfer of the pixel that completes its window
// when the receiver stalls, results back up through the pipeline; pixels
//   that produce no result still flow through the line store stage, and the
//   pixel port drops ready only once the result stages are all full
// reset clears the scan position, the pipeline valids and the registers
//   (kernel zero, 1024 x 1024, shift 10); the line stores are not cleared,
//   zero padding keeps stale entries out of the sums
module zero_padded_2d_convolution #(
  parameter int KERNEL_SIZE = zpc_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = zpc_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS  = zpc_pkg::PIXEL_BITS_DEF,
  parameter int COEF_BITS   = zpc_pkg::COEF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  zpc_pix_if.sink   pixels,
  zpc_res_if.source results,
  zpc_cfg_if.sink   cfg
);

  localparam int HALF  = KERNEL_SIZE / 2;
  localparam int AFTER = KERNEL_SIZE - 1 - HALF;
  // line stores: one per kernel row above the newest one
  localparam int LINES = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  // signed column math, holds -HALF .. MAX_WIDTH+HALF
  localparam int XW    = CW + 2;
  localparam int RW    = zpc_pkg::ROW_BITS;
  localparam int ORW   = RW + 1;
  // product, row sum and total sum widths
  localparam int PW    = COEF_BITS + PIXEL_BITS + 1;
  localparam int RSW   = PW + 3;
  localparam int AW    = RSW + 3;
  localparam int SW    = zpc_pkg::SUM_BITS;
  localparam int OW    = zpc_pkg::OUT_BITS;
  localparam int SHW   = zpc_pkg::SHIFT_REG_BITS;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [zpc_pkg::CFG_DATA_BITS-1:0]   coef_row [0:zpc_pkg::MAX_KERNEL-1];
  logic [zpc_pkg::WIDTH_REG_BITS-1:0]  image_width;
  logic [zpc_pkg::HEIGHT_REG_BITS-1:0] image_height;
  logic [SHW-1:0]                      frac_shift;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < zpc_pkg::MAX_KERNEL; r++) begin
        coef_row[r] <= '0;
      end
      image_width  <= zpc_pkg::WIDTH_RESET;
      image_height <= zpc_pkg::HEIGHT_RESET;
      frac_shift   <= zpc_pkg::SHIFT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        zpc_pkg::REG_COEF_ROW_0:   coef_row[0] <= cfg.data;
        zpc_pkg::REG_COEF_ROW_1:   coef_row[1] <= cfg.data;
        zpc_pkg::REG_COEF_ROW_2:   coef_row[2] <= cfg.data;
        zpc_pkg::REG_COEF_ROW_3:   coef_row[3] <= cfg.data;
        zpc_pkg::REG_COEF_ROW_4:   coef_row[4] <= cfg.data;
        zpc_pkg::REG_IMAGE_WIDTH:  image_width <= cfg.data[zpc_pkg::WIDTH_REG_BITS-1:0];
        zpc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data[zpc_pkg::HEIGHT_REG_BITS-1:0];
        zpc_pkg::REG_FRAC_SHIFT:   frac_shift <= cfg.data[SHW-1:0];
        default: ;
      endcase
    end
  end

  // width clamped to 1 .. MAX_WIDTH, height at least 1
  logic        [XW-1:0]                      w_eff;
  logic        [zpc_pkg::HEIGHT_REG_BITS-1:0] h_eff;
  logic signed [XW-1:0]                      w_s;
  logic signed [ORW-1:0]                     h_s;

  always_comb begin
    if (image_width == '0) begin
      w_eff = XW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(image_width);
    end
    h_eff = (image_height == '0) ? zpc_pkg::HEIGHT_REG_BITS'(1) : image_height;
    w_s   = $signed(w_eff);
    h_s   = $signed(ORW'(h_eff));
  end

  // ---------------------------------------------------------------------
  // pipeline flow control
  // ---------------------------------------------------------------------
  logic s1_valid, s1_res, s2_valid, s3_valid, s4_valid, s5_valid, o_valid;
  logic s1_free, s1_leave, s2_free, s3_free, s4_free, s5_free, o_free;
  logic accept;

  assign o_free   = !o_valid || results.ready;
  assign s5_free  = !s5_valid || o_free;
  assign s4_free  = !s4_valid || s5_free;
  assign s3_free  = !s3_valid || s4_free;
  assign s2_free  = !s2_valid || s3_free;
  // a pixel whose lagged position yields no result leaves stage 1 at once
  assign s1_leave = s1_valid && (!s1_res || s2_free);
  assign s1_free  = !s1_valid || !s1_res || s2_free;

  assign pixels.ready = !rst && s1_free;
  assign accept       = pixels.valid && pixels.ready;

  // ---------------------------------------------------------------------
  // scan position and output position
  // ---------------------------------------------------------------------
  logic [RW-1:0] scan_row;
  logic [CW-1:0] scan_col;

  // output position is the scan position AFTER rows and AFTER pixels back
  logic signed [ORW-1:0] orow;
  logic signed [XW-1:0]  ocol;
  logic signed [ORW-1:0] rpos [0:KERNEL_SIZE-1];
  logic signed [XW-1:0]  cpos [0:KERNEL_SIZE-1];
  logic [KERNEL_SIZE-1:0] row_ok, col_ok;
  logic last_col, res_now, eof_now, wrap, in_pad;

  always_comb begin
    if (w_eff == XW'(1)) begin
      // one pixel per row: the whole lag is in rows
      orow = $signed(ORW'(scan_row) - ORW'(2 * AFTER));
      ocol = '0;
    end else if (XW'(scan_col) >= XW'(AFTER)) begin
      orow = $signed(ORW'(scan_row) - ORW'(AFTER));
      ocol = $signed(XW'(scan_col) - XW'(AFTER));
    end else begin
      // lagged column wraps into the row above
      orow = $signed(ORW'(scan_row) - ORW'(AFTER + 1));
      ocol = $signed(XW'(scan_col) + w_eff - XW'(AFTER));
    end

    last_col = (ocol == w_s - XW'(1));
    res_now  = (orow >= 0) && (orow < h_s);
    eof_now  = last_col && (orow == h_s - ORW'(1));
    // frame done, or position already past frame plus lag
    wrap     = (orow >= h_s) || eof_now;
    // filler, or a position below the last frame row
    in_pad   = pixels.filler || ($signed(ORW'(scan_row)) >= h_s);

    // zero padding masks for every window row and column
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      rpos[i]   = orow + ORW'(i - HALF);
      row_ok[i] = (rpos[i] >= 0) && (rpos[i] < h_s);
      cpos[i]   = ocol + XW'(i - HALF);
      col_ok[i] = (cpos[i] >= 0) && (cpos[i] < w_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
      scan_col <= '0;
    end else if (accept) begin
      if (wrap) begin
        scan_row <= '0;
        scan_col <= '0;
      end else if (XW'(scan_col) + XW'(1) >= w_eff) begin
        scan_col <= '0;
        scan_row <= scan_row + RW'(1);
      end else begin
        scan_col <= scan_col + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: line stores and window
  // ---------------------------------------------------------------------
  logic [PIXEL_BITS-1:0]  s1_pix;
  logic [CW-1:0]          s1_col;
  logic [KERNEL_SIZE-1:0] s1_row_ok, s1_col_ok;
  logic                   s1_eor, s1_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= in_pad ? '0 : pixels.pixel_in;
      s1_col    <= scan_col;
      s1_res    <= res_now;
      s1_row_ok <= row_ok;
      s1_col_ok <= col_ok;
      s1_eor    <= last_col;
      s1_eof    <= eof_now;
    end
  end

  // line store k holds the column of the row k+1 lines above the newest pixel
  logic [PIXEL_BITS-1:0] line_mem [0:LINES-1][0:MAX_WIDTH-1];
  logic [PIXEL_BITS-1:0] rd       [0:LINES-1];
  logic [PIXEL_BITS-1:0] wd       [0:LINES-1];
  logic [PIXEL_BITS-1:0] newest   [0:KERNEL_SIZE-1];
  logic [PIXEL_BITS-1:0] hist     [0:KERNEL_SIZE-1][0:LINES-1];
  logic [PIXEL_BITS-1:0] tap      [0:KERNEL_SIZE-1][0:KERNEL_SIZE-1];

  always_comb begin
    wd[0] = s1_pix;
    for (int k = 1; k < LINES; k++) begin
      wd[k] = rd[k-1];
    end
    newest[0] = s1_pix;
    for (int k = 1; k < KERNEL_SIZE; k++) begin
      newest[k] = rd[k-1];
    end
    // tap[k][m]: pixel k rows and m positions behind the newest one
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      tap[k][0] = newest[k];
      for (int m = 1; m < KERNEL_SIZE; m++) begin
        tap[k][m] = hist[k][m-1];
      end
    end
  end

  // write of the stage 1 pixel repeats while it waits, always the same data;
  // a read at the column being written takes the write data
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int k = 0; k < LINES; k++) begin
        line_mem[k][s1_col] <= wd[k];
      end
    end
    if (accept) begin
      for (int k = 0; k < LINES; k++) begin
        rd[k] <= (s1_valid && s1_col == scan_col) ? wd[k] : line_mem[k][scan_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        hist[k][0] <= newest[k];
        for (int m = 1; m < LINES; m++) begin
          hist[k][m] <= hist[k][m-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: masked products
  // ---------------------------------------------------------------------
  logic signed [COEF_BITS-1:0]  coef      [0:KERNEL_SIZE-1][0:KERNEL_SIZE-1];
  logic        [PIXEL_BITS-1:0] mpix      [0:KERNEL_SIZE-1][0:KERNEL_SIZE-1];
  logic signed [PW-1:0]         prod_next [0:KERNEL_SIZE-1][0:KERNEL_SIZE-1];
  logic signed [PW-1:0]         s2_prod   [0:KERNEL_SIZE-1][0:KERNEL_SIZE-1];
  logic                         s2_eor, s2_eof;

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        coef[i][j] = $signed(coef_row[i][COEF_BITS*j +: COEF_BITS]);
        // kernel row i, column j sits on the pixel KERNEL_SIZE-1-i rows back
        mpix[i][j] = (s1_row_ok[i] && s1_col_ok[j]) ?
                     tap[KERNEL_SIZE-1-i][KERNEL_SIZE-1-j] : '0;
        prod_next[i][j] = coef[i][j] * $signed({1'b0, mpix[i][j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_prod <= prod_next;
      s2_eor  <= s1_eor;
      s2_eof  <= s1_eof;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: row sums
  // ---------------------------------------------------------------------
  logic signed [RSW-1:0] rsum_next [0:KERNEL_SIZE-1];
  logic signed [RSW-1:0] s3_rsum   [0:KERNEL_SIZE-1];
  logic                  s3_eor, s3_eof;

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      rsum_next[i] = '0;
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        rsum_next[i] = rsum_next[i] + RSW'(s2_prod[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_rsum <= rsum_next;
      s3_eor  <= s2_eor;
      s3_eof  <= s2_eof;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: window sum
  // ---------------------------------------------------------------------
  logic signed [AW-1:0] acc_next, s4_acc;
  logic                 s4_eor, s4_eof;

  always_comb begin
    acc_next = '0;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      acc_next = acc_next + AW'(s3_rsum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_free) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_free) begin
      s4_acc <= acc_next;
      s4_eor <= s3_eor;
      s4_eof <= s3_eof;
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: magnitude
  // ---------------------------------------------------------------------
  logic signed [AW-1:0] s5_acc;
  logic        [AW-1:0] s5_mag;
  logic                 s5_eor, s5_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_free) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_free) begin
      s5_acc <= s4_acc;
      s5_mag <= (s4_acc < 0) ? AW'(-s4_acc) : AW'(s4_acc);
      s5_eor <= s4_eor;
      s5_eof <= s4_eof;
    end
  end

  // ---------------------------------------------------------------------
  // output register: rounding shift and byte clip
  // ---------------------------------------------------------------------
  logic [AW:0] half, rnd;
  logic        sat;

  always_comb begin
    half = (frac_shift == '0) ? '0 : ((AW+1)'(1) << (frac_shift - SHW'(1)));
    rnd  = ({1'b0, s5_mag} + half) >> frac_shift;
    sat  = rnd > (AW+1)'(zpc_pkg::OUT_MAX);
  end

  logic signed [SW-1:0] o_raw;
  logic        [OW-1:0] o_pix;
  logic                 o_sat, o_eor, o_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      o_raw <= SW'(s5_acc);
      o_pix <= sat ? zpc_pkg::OUT_MAX : rnd[OW-1:0];
      o_sat <= sat;
      o_eor <= s5_eor;
      o_eof <= s5_eof;
    end
  end

  assign results.valid        = o_valid;
  assign results.raw_sum      = o_raw;
  assign results.out_pixel    = o_pix;
  assign results.saturated    = o_sat;
  assign results.end_of_row   = o_eor;
  assign results.end_of_frame = o_eof;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // the pixel that ends the frame (or overruns it) restarts the scan
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && wrap |=> scan_row == '0 && scan_col == '0)
    else $error("scan position not restarted after frame end");

  // the pixel port only stalls when a result-bearing pixel is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> s1_valid && s1_res && s2_valid)
    else $error("pixel port stalled without a blocked result");

  // the last position of a frame is also the last of its row
  a_frame_end_row: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.end_of_frame |-> results.end_of_row)
    else $error("frame end without row end");

endmodule

[bench/zero_padded_2d_convolution_tb.sv]
module zero_padded_2d_convolution_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zpc_pkg::*;

  // window geometry at the default build
  localparam int KS          = KERNEL_SIZE_DEF;
  localparam int HALF        = KS / 2;
  localparam int AFTER       = KS - 1 - HALF;
  localparam int STORE_DEPTH = (KS - 1) * MAX_WIDTH_DEF + KS;

  // run pacing
  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;

  localparam logic [CFG_INDEX_BITS-1:0] COEF_REG [MAX_KERNEL] = '{
    REG_COEF_ROW_0, REG_COEF_ROW_1, REG_COEF_ROW_2, REG_COEF_ROW_3, REG_COEF_ROW_4
  };

  typedef enum int {
    KERN_RANDOM, KERN_MAX, KERN_MIN, KERN_IDENTITY, KERN_CENTER_3X3, KERN_SEPARABLE,
    KERN_SMALL, KERN_COUNT
  } kernel_kind_e;

  typedef enum int {SINK_OPEN, SINK_SPOTTY, SINK_CLOGGED} sink_mode_e;

  typedef struct packed {
    logic [7:0] value;
    logic       filler;
  } pix_item_t;

  typedef struct {
    logic signed [SUM_BITS-1:0] raw_sum;
    logic [OUT_BITS-1:0]        out_pixel;
    logic                       saturated;
    logic                       end_of_row;
    logic                       end_of_frame;
  } filtered_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  zpc_pix_if pix_bus ();
  zpc_res_if res_bus ();
  zpc_cfg_if cfg_bus ();

  zero_padded_2d_convolution dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_bus),
    .results (res_bus),
    .cfg     (cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // filter prediction: register copy, pixel history and scan position
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_BITS-1:0]   coef_regs [MAX_KERNEL];
  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;
  logic [SHIFT_REG_BITS-1:0]  shift_reg;
  logic [7:0]                 stream_hist [STORE_DEPTH];
  int                         scan_row;
  int                         scan_col;

  filtered_t filtered_q [$];   // filtered pixels still owed by the block
  pix_item_t pixel_q [$];      // pixels not yet handed to the driver
  int        items_in_flight = 0;
  int        mismatches = 0;

  // kernel staged for the next round of register writes
  logic [CFG_DATA_BITS-1:0] kernel_rows [MAX_KERNEL];

  // width 0 behaves as 1 and anything past the line store as a full line
  function automatic int eff_width(input int w_reg);
    if (w_reg < 1) return 1;
    if (w_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return w_reg;
  endfunction

  function automatic int eff_height(input int h_reg);
    return (h_reg < 1) ? 1 : h_reg;
  endfunction

  // pixels that must follow a position before its window is complete
  function automatic int frame_lag(input int w);
    return AFTER * w + AFTER;
  endfunction

  function automatic void clear_model();
    int k;
    for (k = 0; k < MAX_KERNEL; k++) coef_regs[k] = '0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    shift_reg  = SHIFT_RESET;
    for (k = 0; k < STORE_DEPTH; k++) stream_hist[k] = 8'h00;
    scan_row = 0;
    scan_col = 0;
  endfunction

  // one accepted pixel: store it, emit the window that it completes, move on
  function automatic void filter_step(input logic [7:0] pixel_value, input logic is_filler);
    int w, h, sh, total, lag, n, p, orow, ocol, sr, sc, cv, i, j;
    logic [7:0] pix;
    logic signed [COEF_BITS_DEF-1:0] coef;
    longint acc, mag;
    filtered_t res;
    w     = eff_width(int'(width_reg));
    h     = eff_height(int'(height_reg));
    sh    = int'(shift_reg);
    total = w * h;
    lag   = frame_lag(w);
    n     = scan_row * w + scan_col;
    // fillers and anything past the last frame pixel count as black
    pix = (is_filler || n >= total) ? 8'h00 : pixel_value;
    stream_hist[n % STORE_DEPTH] = pix;
    if (n >= lag && n - lag < total) begin
      p    = n - lag;
      orow = p / w;
      ocol = p % w;
      acc  = 0;
      for (i = 0; i < KS; i++) begin
        for (j = 0; j < KS; j++) begin
          sr = orow - HALF + i;
          sc = ocol - HALF + j;
          if (sr >= 0 && sr < h && sc >= 0 && sc < w) begin
            coef = coef_regs[i][COEF_BITS_DEF*j +: COEF_BITS_DEF];
            cv   = coef;
            acc += longint'(cv) * longint'(int'(stream_hist[(sr * w + sc) % STORE_DEPTH]));
          end
        end
      end
      mag = (acc < 0) ? -acc : acc;
      if (sh > 0) mag = (mag + (longint'(1) << (sh - 1))) >> sh;
      res.saturated    = (mag > 255);
      res.out_pixel    = res.saturated ? OUT_MAX : mag[OUT_BITS-1:0];
      res.raw_sum      = acc[SUM_BITS-1:0];
      res.end_of_row   = (ocol == w - 1);
      res.end_of_frame = (p == total - 1);
      filtered_q.push_back(res);
    end
    // wrap to a new frame once the lag is drained or the scan overran the frame
    if (n + 1 >= total + lag) begin
      scan_row = 0;
      scan_col = 0;
    end else begin
      scan_col++;
      if (scan_col >= w) begin
        scan_col = 0;
        scan_row++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void make_kernel(input kernel_kind_e kind);
    int a [MAX_KERNEL];
    int b [MAX_KERNEL];
    int v, i, j;
    for (i = 0; i < MAX_KERNEL; i++) begin
      a[i] = int'($urandom_range(0, 63)) - 32;
      b[i] = int'($urandom_range(0, 63)) - 32;
    end
    for (i = 0; i < MAX_KERNEL; i++) begin
      for (j = 0; j < MAX_KERNEL; j++) begin
        case (kind)
          KERN_MAX:      v = 2047;
          KERN_MIN:      v = -2048;
          KERN_IDENTITY: v = (i == HALF && j == HALF) ? 1024 : 0;
          // 3x3 mask loaded into the middle of the 5x5 array
          KERN_CENTER_3X3: begin
            if (i >= HALF - 1 && i <= HALF + 1 && j >= HALF - 1 && j <= HALF + 1)
              v = int'($urandom_range(0, 4095)) - 2048;
            else
              v = 0;
          end
          // separable mask as outer product of two short vectors
          KERN_SEPARABLE: v = a[i] * b[j];
          KERN_SMALL:     v = int'($urandom_range(0, 127)) - 64;
          default:        v = int'($urandom_range(0, 4095)) - 2048;
        endcase
        kernel_rows[i][COEF_BITS_DEF*j +: COEF_BITS_DEF] = v[COEF_BITS_DEF-1:0];
      end
    end
  endfunction

  function automatic void queue_item(input logic [7:0] value, input logic filler);
    pix_item_t item;
    item.value  = value;
    item.filler = filler;
    pixel_q.push_back(item);
    items_in_flight++;
  endfunction

  // frame pixels get an occasional filler; lag items are mostly filler, the
  // rest carry a pixel that must be ignored
  function automatic void queue_span(input int count, input bit in_frame);
    int k;
    logic [7:0] value;
    logic filler;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0:       value = 8'h00;
        1:       value = 8'hFF;
        default: value = 8'($urandom);
      endcase
      filler = in_frame ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 3) != 0);
      queue_item(value, filler);
    end
  endfunction

  function automatic void queue_frame(input int w, input int h);
    queue_span(w * h, 1'b1);
    queue_span(frame_lag(w), 1'b0);
  endfunction

  // register write; the caller drops valid after the last one of a batch
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = value[WIDTH_REG_BITS-1:0];
      REG_IMAGE_HEIGHT: height_reg = value[HEIGHT_REG_BITS-1:0];
      REG_FRAC_SHIFT:   shift_reg  = value[SHIFT_REG_BITS-1:0];
      REG_COEF_ROW_0, REG_COEF_ROW_1, REG_COEF_ROW_2, REG_COEF_ROW_3, REG_COEF_ROW_4:
        coef_regs[idx] = value;
      default: ;
    endcase
  endtask

  task automatic configure(input int w_reg, input int h_reg, input int sh);
    int k;
    for (k = 0; k < MAX_KERNEL; k++) write_reg(COEF_REG[k], kernel_rows[k]);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w_reg));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h_reg));
    write_reg(REG_FRAC_SHIFT, CFG_DATA_BITS'(sh));
    cfg_bus.valid <= 1'b0;
  endtask

  // block idle: every pixel sent, every filtered pixel back, pipeline flushed
  task automatic wait_drained();
    do @(negedge clk); while (items_in_flight != 0 || filtered_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // pixel driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  pix_item_t next_item;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pix_bus.valid <= 1'b0;
    end else begin
      // transfer at this edge: predict before anything else moves
      if (pix_bus.valid && pix_bus.ready) begin
        filter_step(pix_bus.pixel_in, pix_bus.filler);
        items_in_flight--;
      end
      if (!pix_bus.valid || pix_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_bus.valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          next_item = pixel_q.pop_front();
          pix_bus.valid    <= 1'b1;
          pix_bus.pixel_in <= next_item.value;
          pix_bus.filler   <= next_item.filler;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a zero gap merges bursts into long unbroken runs
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks every transfer, stalls on a changing pattern
  // ---------------------------------------------------------------------------
  filtered_t  seen, owed;
  sink_mode_e sink_mode = SINK_OPEN;
  int         mode_left = 0;
  int         stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        seen.raw_sum      = res_bus.raw_sum;
        seen.out_pixel    = res_bus.out_pixel;
        seen.saturated    = res_bus.saturated;
        seen.end_of_row   = res_bus.end_of_row;
        seen.end_of_frame = res_bus.end_of_frame;
        if (filtered_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result: sum %0d pix %0d sat %0b eor %0b eof %0b",
                     seen.raw_sum, seen.out_pixel, seen.saturated, seen.end_of_row,
                     seen.end_of_frame);
          mismatches++;
        end else begin
          owed = filtered_q.pop_front();
          if (seen.raw_sum !== owed.raw_sum || seen.out_pixel !== owed.out_pixel ||
              seen.saturated !== owed.saturated || seen.end_of_row !== owed.end_of_row ||
              seen.end_of_frame !== owed.end_of_frame) begin
            if (mismatches < REPORT_LIMIT)
              $display("result differs: expected sum %0d pix %0d sat %0b eor %0b eof %0b, %s",
                       owed.raw_sum, owed.out_pixel, owed.saturated, owed.end_of_row,
                       owed.end_of_frame,
                       $sformatf("got sum %0d pix %0d sat %0b eor %0b eof %0b",
                                 seen.raw_sum, seen.out_pixel, seen.saturated,
                                 seen.end_of_row, seen.end_of_frame));
            mismatches++;
          end
        end
      end
      // stall pattern switches between open, spotty and long blockages
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(SINK_OPEN, SINK_CLOGGED));
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_OPEN:   res_bus.ready <= 1'b1;
        SINK_SPOTTY: res_bus.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            res_bus.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(3, 30);
            res_bus.ready <= 1'b0;
          end else begin
            res_bus.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transfer means the block hung
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  int random_items = 0;
  int w_reg, h_reg, w, h;

  initial begin
    // known levels on every input before the first edge
    pix_bus.valid    = 1'b0;
    pix_bus.pixel_in = '0;
    pix_bus.filler   = 1'b0;
    res_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_COEF_ROW_0;
    cfg_bus.data     = '0;
    clear_model();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // width and height 0 act as a single pixel frame; largest kernel, no
    // shift so the sum saturates; pixels in the lag are ignored, fillers too
    make_kernel(KERN_MAX);
    configure(0, 0, 0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b1);
    queue_item(8'h4D, 1'b0);
    queue_item(8'h00, 1'b1);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_span(frame_lag(1), 1'b0);
    wait_drained();

    // tallest frame, most negative kernel, largest shift; after a pause the
    // height drops below the scan position, so the next item restarts the frame
    make_kernel(KERN_MIN);
    configure(1, 65535, 15);
    queue_item(8'hFF, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b1);
    queue_span(8, 1'b1);
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(3));
    cfg_bus.valid <= 1'b0;
    queue_item(8'hA5, 1'b0);
    queue_frame(1, 3);
    wait_drained();

    // separable kernel; mid-frame the height grows and the center row and
    // shift change, taking effect from the next pixel
    make_kernel(KERN_SEPARABLE);
    configure(4, 3, 4);
    queue_span(12, 1'b1);
    wait_drained();
    make_kernel(KERN_CENTER_3X3);
    write_reg(REG_COEF_ROW_2, kernel_rows[2]);
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(5));
    write_reg(REG_FRAC_SHIFT, CFG_DATA_BITS'(9));
    cfg_bus.valid <= 1'b0;
    queue_span(8, 1'b1);
    queue_span(frame_lag(4), 1'b0);
    wait_drained();

    // register width past the line store clamps to a full line; one row only
    make_kernel(KERN_IDENTITY);
    configure(2047, 1, 10);
    queue_frame(MAX_WIDTH_DEF, 1);
    wait_drained();

    // random frames: mostly small, now and then wider, each setting run for
    // one to three back to back frames
    while (random_items < RANDOM_ITEMS) begin
      wait_drained();
      make_kernel(kernel_kind_e'($urandom_range(KERN_RANDOM, KERN_COUNT - 1)));
      case ($urandom_range(0, 9))
        0:       w_reg = $urandom_range(13, 40);
        1:       w_reg = $urandom_range(0, 1);
        default: w_reg = $urandom_range(2, 12);
      endcase
      h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      configure(w_reg, h_reg, $urandom_range(0, 15));
      w = eff_width(w_reg);
      h = eff_height(h_reg);
      repeat ($urandom_range(1, 3)) begin
        queue_frame(w, h);
        random_items += w * h + frame_lag(w);
      end
    end
    wait_drained();

    mismatches += filtered_q.size();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
